@@ design/assert_macros.svh @@
// Assertion macros used by the RTL of the Bezier evaluator.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/cbal_pkg.sv @@
// Package for the cubic Bezier arc length evaluator: widths, op codes,
// register indexes and fixed-point constants. No dependencies.
package cbal_pkg;

  localparam int COORD_W    = 32;
  localparam int LEN_W      = 40;
  localparam int OP_W       = 2;
  localparam int SUBDIV_W   = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_REGS   = 8;
  localparam int T_W        = 17;
  localparam int DIV_NUM_W  = 48;
  localparam int DIV_DEN_W  = 33;
  localparam int SQ_SRC_W   = 66;
  localparam int SQ_RES_W   = 33;
  localparam int SQ_STEPS   = 33;
  localparam int MAX_SUBDIV_DEF = 256;

  localparam logic [T_W-1:0]   Q_ONE   = 17'h10000;
  localparam logic [LEN_W-1:0] LEN_MAX = 40'hFF_FFFF_FFFF;

  localparam logic [OP_W-1:0] OP_EVAL = 2'd0;
  localparam logic [OP_W-1:0] OP_LEN  = 2'd1;
  localparam logic [OP_W-1:0] OP_DIST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_START_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GUIDE1_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GUIDE1_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GUIDE2_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GUIDE2_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_END_X    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y    = 3'd7;

endpackage

@@ design/cubic_bezier_arc_length_evaluator.sv @@
// Cubic Bezier evaluator with chord-sum arc length, Q16.16 fixed point.
// Depends on cbal_pkg and assert_macros.svh.
//
// Usage:
// - Control points load over the cfg port (cfg_we, cfg_index, cfg_wdata), one
//   register per cycle, only while the block is idle; the user is bound to
//   this, the block does not enforce it. The input channel (in_valid / in_stall)
//   carries one transaction: op, position and subdivisions. Op 0 evaluates at
//   a clamped parameter, op 1 returns the chord-sum length, op 2 the point at a distance.
// - Each transaction gives exactly one result on out_valid / out_stall.
// The work is done by one shared multiplier, one restoring divider (48
// steps) and one bit-pair square root (33 steps) run by a sequencer:
// - op 0 runs the de Casteljau lerps only; op 3 goes straight to the result.
// - ops 1 and 2 run a divide, the lerps and a square root per chord walked;
//   op 2 adds a divide and a final interpolation.
// - in_stall is high while a transaction is in work; one transaction at a time.
// A finished result sits in the output register; the next transaction is
// accepted while the receiver stalls it. Reset (rst_n low, synchronous)
// clears all control points to zero and empties the output register.
`include "assert_macros.svh"

module cubic_bezier_arc_length_evaluator
  import cbal_pkg::*;
#(
  parameter int MAX_SUBDIVISIONS = MAX_SUBDIV_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [COORD_W-1:0]          cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [OP_W-1:0]             in_op,
  input  logic signed [COORD_W-1:0]   in_position,
  input  logic [SUBDIV_W-1:0]         in_subdivisions,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [COORD_W-1:0]   out_point_x,
  output logic signed [COORD_W-1:0]   out_point_y,
  output logic [LEN_W-1:0]            out_arc_length
);

  // Chord counter holds 1..MAX; accumulator holds MAX chords of up to 33 bits
  // and is at least one bit wider than the saturated length.
  localparam int I_W    = $clog2(MAX_SUBDIVISIONS + 1);
  localparam int ACC_W  = (34 + $clog2(MAX_SUBDIVISIONS) > LEN_W + 1) ?
                          34 + $clog2(MAX_SUBDIVISIONS) : LEN_W + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_TDIV  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_EV_M  = 4'd4;
  localparam logic [3:0] S_EV_A  = 4'd5;
  localparam logic [3:0] S_SQX   = 4'd6;
  localparam logic [3:0] S_SQY   = 4'd7;
  localparam logic [3:0] S_SUM   = 4'd8;
  localparam logic [3:0] S_SQRT  = 4'd9;
  localparam logic [3:0] S_CHORD = 4'd10;
  localparam logic [3:0] S_FIN_M = 4'd11;
  localparam logic [3:0] S_FIN_A = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  // Control point registers
  logic signed [COORD_W-1:0] regs_r [NUM_REGS];

  // Sequencer
  logic [3:0]                state_r;
  logic [OP_W-1:0]           op_r;
  logic signed [COORD_W-1:0] pos_r;
  logic [I_W-1:0]            n_r;
  logic [I_W-1:0]            i_r;
  logic [2:0]                k_r;
  logic                      crd_r;
  logic [T_W-1:0]            t_r;

  // Curve scratch and chord walk
  logic signed [COORD_W-1:0] s0_r, s1_r, s2_r, s3_r, s4_r;
  logic signed [COORD_W-1:0] px_r, py_r, cx_r, cy_r;
  logic [ACC_W-1:0]          acc_r;
  logic [SQ_RES_W-1:0]       seg_r;

  // Shared multiplier
  logic signed [32:0]        mul_a, mul_b;
  logic signed [65:0]        prod_r;
  logic [64:0]               sum0_r;

  // Divider
  logic [DIV_NUM_W-1:0]      dv_num_r;
  logic [DIV_DEN_W-1:0]      dv_rem_r;
  logic [DIV_DEN_W-1:0]      dv_den_r;
  logic [5:0]                dv_cnt_r;
  logic                      dv_frac_r;

  // Square root
  logic [SQ_SRC_W-1:0]       sq_src_r;
  logic [34:0]               sq_rem_r;
  logic [SQ_RES_W-1:0]       sq_res_r;
  logic [5:0]                sq_cnt_r;

  // Result staging and output register
  logic signed [COORD_W-1:0] res_x_r, res_y_r;
  logic [LEN_W-1:0]          res_len_r;
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_x_r, out_y_r;
  logic [LEN_W-1:0]          out_len_r;

  logic                      in_acc;
  logic                      load_out;

  assign in_stall       = (state_r != S_IDLE);
  assign in_acc         = in_valid && !in_stall;
  assign load_out       = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign out_valid      = out_valid_r;
  assign out_point_x    = out_x_r;
  assign out_point_y    = out_y_r;
  assign out_arc_length = out_len_r;

  // ---------------------------------------------------------------------
  // Lerp operands: de Casteljau tree for the curve, chord for the final
  // interpolation of op 2.
  // ---------------------------------------------------------------------
  logic signed [COORD_W-1:0] p0, p1, p2, p3, la, lb;
  logic signed [33:0]        lerp_sum;
  logic signed [COORD_W-1:0] lerp_res;

  assign p0 = crd_r ? regs_r[REG_START_Y]  : regs_r[REG_START_X];
  assign p1 = crd_r ? regs_r[REG_GUIDE1_Y] : regs_r[REG_GUIDE1_X];
  assign p2 = crd_r ? regs_r[REG_GUIDE2_Y] : regs_r[REG_GUIDE2_X];
  assign p3 = crd_r ? regs_r[REG_END_Y]    : regs_r[REG_END_X];

  always_comb begin
    if (state_r == S_FIN_M || state_r == S_FIN_A) begin
      la = crd_r ? py_r : px_r;
      lb = crd_r ? cy_r : cx_r;
    end else begin
      unique case (k_r)
        3'd0:    begin la = p0;   lb = p1;   end
        3'd1:    begin la = p1;   lb = p2;   end
        3'd2:    begin la = p2;   lb = p3;   end
        3'd3:    begin la = s0_r; lb = s1_r; end
        3'd4:    begin la = s1_r; lb = s2_r; end
        default: begin la = s3_r; lb = s4_r; end
      endcase
    end
  end

  // |(b-a)*t| < 2^49, so bits 49:16 carry the floored quotient by 65536
  assign lerp_sum = {{2{la[COORD_W-1]}}, la} + prod_r[49:16];
  assign lerp_res = lerp_sum[COORD_W-1:0];

  always_comb begin
    unique case (state_r)
      S_SQX: begin
        mul_a = 33'(cx_r) - 33'(px_r);
        mul_b = mul_a;
      end
      S_SQY: begin
        mul_a = 33'(cy_r) - 33'(py_r);
        mul_b = mul_a;
      end
      default: begin
        mul_a = 33'(lb) - 33'(la);
        mul_b = $signed({16'b0, t_r});
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Restoring divider step and square root step
  // ---------------------------------------------------------------------
  logic [DIV_DEN_W:0]   dv_trial;
  logic                 dv_ge;
  logic [DIV_DEN_W-1:0] dv_rem_nxt;
  logic [DIV_NUM_W-1:0] dv_num_nxt;

  assign dv_trial   = {dv_rem_r, dv_num_r[DIV_NUM_W-1]};
  assign dv_ge      = dv_trial >= {1'b0, dv_den_r};
  assign dv_rem_nxt = dv_ge ? DIV_DEN_W'(dv_trial - {1'b0, dv_den_r})
                            : DIV_DEN_W'(dv_trial);
  assign dv_num_nxt = {dv_num_r[DIV_NUM_W-2:0], dv_ge};

  logic [36:0]         sq_rem2;
  logic [36:0]         sq_trial;
  logic                sq_ge;
  logic [SQ_RES_W-1:0] sq_res_nxt;

  assign sq_rem2    = {sq_rem_r, sq_src_r[SQ_SRC_W-1 -: 2]};
  assign sq_trial   = 37'({sq_res_r, 2'b01});
  assign sq_ge      = sq_rem2 >= sq_trial;
  assign sq_res_nxt = {sq_res_r[SQ_RES_W-2:0], sq_ge};

  // ---------------------------------------------------------------------
  // Chord bookkeeping
  // ---------------------------------------------------------------------
  logic [ACC_W-1:0] acc_seg;
  logic             hit;
  logic [30:0]      dist_rem;

  assign acc_seg  = acc_r + ACC_W'(seg_r);
  assign hit      = (op_r == OP_DIST) && (seg_r != '0) &&
                    (acc_seg >= ACC_W'(pos_r[30:0]));
  assign dist_rem = pos_r[30:0] - acc_r[30:0];

  logic [31:0] sub_w, n_cl;
  assign sub_w = 32'(in_subdivisions);
  assign n_cl  = (sub_w == 32'd0) ? 32'd1 :
                 (sub_w > 32'(MAX_SUBDIVISIONS)) ? 32'(MAX_SUBDIVISIONS) : sub_w;

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  logic [3:0]     state_nxt;
  logic           out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_SETUP;
      S_SETUP: begin
        priority if (op_r == OP_EVAL) state_nxt = S_EV_M;
        else if (op_r == OP_LEN) state_nxt = S_TDIV;
        else if (op_r == OP_DIST) state_nxt = (pos_r <= 0) ? S_DONE : S_TDIV;
        else state_nxt = S_DONE;
      end
      S_TDIV:  state_nxt = S_DIV;
      S_DIV: begin
        if (dv_cnt_r == 6'(DIV_NUM_W - 1)) state_nxt = dv_frac_r ? S_FIN_M : S_EV_M;
      end
      S_EV_M:  state_nxt = S_EV_A;
      S_EV_A: begin
        priority if (k_r != 3'd5 || !crd_r) state_nxt = S_EV_M;
        else if (op_r == OP_EVAL) state_nxt = S_DONE;
        else state_nxt = S_SQX;
      end
      S_SQX:   state_nxt = S_SQY;
      S_SQY:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_SQRT;
      S_SQRT:  if (sq_cnt_r == 6'(SQ_STEPS - 1)) state_nxt = S_CHORD;
      S_CHORD: begin
        priority if (hit) state_nxt = S_DIV;
        else if (i_r == n_r) state_nxt = S_DONE;
        else state_nxt = S_TDIV;
      end
      S_FIN_M: state_nxt = S_FIN_A;
      S_FIN_A: state_nxt = crd_r ? S_DONE : S_FIN_M;
      S_DONE:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (load_out) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int r = 0; r < NUM_REGS; r++) regs_r[r] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) regs_r[cfg_index] <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r  <= in_op;
          pos_r <= in_position;
          n_r   <= n_cl[I_W-1:0];
        end
      end
      S_SETUP: begin
        res_len_r <= '0;
        k_r       <= 3'd0;
        crd_r     <= 1'b0;
        i_r       <= I_W'(1);
        acc_r     <= '0;
        px_r      <= regs_r[REG_START_X];
        py_r      <= regs_r[REG_START_Y];
        // clamp the parameter into 0..1
        priority if (pos_r < 0) t_r <= '0;
        else if (pos_r > $signed(32'(Q_ONE))) t_r <= Q_ONE;
        else t_r <= pos_r[T_W-1:0];
        if (op_r == OP_DIST && pos_r <= 0) begin
          res_x_r <= regs_r[REG_START_X];
          res_y_r <= regs_r[REG_START_Y];
        end else begin
          res_x_r <= '0;
          res_y_r <= '0;
        end
      end
      S_TDIV: begin
        // t_i = round(i * 65536 / n), halves up
        dv_num_r  <= DIV_NUM_W'({i_r, 16'b0}) + DIV_NUM_W'(n_r >> 1);
        dv_den_r  <= DIV_DEN_W'(n_r);
        dv_rem_r  <= '0;
        dv_cnt_r  <= '0;
        dv_frac_r <= 1'b0;
      end
      S_DIV: begin
        dv_num_r <= dv_num_nxt;
        dv_rem_r <= dv_rem_nxt;
        dv_cnt_r <= dv_cnt_r + 6'd1;
        if (dv_cnt_r == 6'(DIV_NUM_W - 1)) begin
          t_r   <= dv_num_nxt[T_W-1:0];
          k_r   <= 3'd0;
          crd_r <= 1'b0;
        end
      end
      S_EV_A: begin
        unique case (k_r)
          3'd0: s0_r <= lerp_res;
          3'd1: s1_r <= lerp_res;
          3'd2: s2_r <= lerp_res;
          3'd3: s3_r <= lerp_res;
          3'd4: s4_r <= lerp_res;
          default: begin
            if (crd_r) begin
              cy_r <= lerp_res;
              if (op_r == OP_EVAL) begin
                res_x_r <= cx_r;
                res_y_r <= lerp_res;
              end
            end else begin
              cx_r  <= lerp_res;
              crd_r <= 1'b1;
            end
          end
        endcase
        k_r <= (k_r == 3'd5) ? 3'd0 : k_r + 3'd1;
      end
      S_SQY: sum0_r <= prod_r[64:0];
      S_SUM: begin
        sq_src_r <= SQ_SRC_W'({1'b0, sum0_r} + {1'b0, prod_r[64:0]});
        sq_rem_r <= '0;
        sq_res_r <= '0;
        sq_cnt_r <= '0;
      end
      S_SQRT: begin
        sq_src_r <= {sq_src_r[SQ_SRC_W-3:0], 2'b00};
        sq_rem_r <= sq_ge ? 35'(sq_rem2 - sq_trial) : 35'(sq_rem2);
        sq_res_r <= sq_res_nxt;
        sq_cnt_r <= sq_cnt_r + 6'd1;
        if (sq_cnt_r == 6'(SQ_STEPS - 1)) seg_r <= sq_res_nxt;
      end
      S_CHORD: begin
        if (hit) begin
          // fraction into this chord = rem * 65536 / seg
          dv_num_r  <= DIV_NUM_W'({dist_rem, 16'b0});
          dv_den_r  <= seg_r;
          dv_rem_r  <= '0;
          dv_cnt_r  <= '0;
          dv_frac_r <= 1'b1;
        end else begin
          acc_r <= acc_seg;
          px_r  <= cx_r;
          py_r  <= cy_r;
          i_r   <= i_r + I_W'(1);
          if (i_r == n_r) begin
            if (op_r == OP_LEN) begin
              res_len_r <= (acc_seg > ACC_W'(LEN_MAX)) ? LEN_MAX : acc_seg[LEN_W-1:0];
            end else begin
              res_x_r <= regs_r[REG_END_X];
              res_y_r <= regs_r[REG_END_Y];
            end
          end
        end
      end
      S_FIN_A: begin
        if (crd_r) res_y_r <= lerp_res;
        else res_x_r <= lerp_res;
        crd_r <= 1'b1;
      end
      default: ;
    endcase

    if (load_out) begin
      out_x_r   <= res_x_r;
      out_y_r   <= res_y_r;
      out_len_r <= res_len_r;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ASSERT_CLK(a_t_in_range, (state_r == S_EV_M || state_r == S_FIN_M) |-> t_r <= Q_ONE,
              "interpolation parameter above one")
  `ASSERT_CLK(a_i_bounded, (state_r == S_TDIV || state_r == S_CHORD) |-> (i_r <= n_r),
              "chord index past subdivision count")
  `ASSERT_CLK(a_out_drains,
              (out_valid_r && !out_stall && state_r != S_DONE) |=> !out_valid_r,
              "output register did not drain after transaction")
  `ASSERT_NEVER(a_accept_busy, in_acc && state_r != S_IDLE,
                "input accepted while a transaction is in work")

endmodule

@@ sim/cubic_bezier_arc_length_evaluator_test.sv @@
// Self-checking testbench for the cubic Bezier arc length evaluator.
// Depends on cbal_pkg and the evaluator RTL; reads and writes no files.
`timescale 1ns / 100ps

module cubic_bezier_arc_length_evaluator_test;
  import cbal_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // unused code, all-zero result
  localparam int MAX_N = 256;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [COORD_W-1:0]  position;
    logic [SUBDIV_W-1:0] subdivisions;
  } query_t;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LEN_W-1:0]   len;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_op = '0;
  logic signed [COORD_W-1:0] in_position = '0;
  logic [SUBDIV_W-1:0] in_subdivisions = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_point_x;
  logic signed [COORD_W-1:0] out_point_y;
  logic [LEN_W-1:0] out_arc_length;

  cubic_bezier_arc_length_evaluator uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_position(in_position), .in_subdivisions(in_subdivisions),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_point_x(out_point_x), .out_point_y(out_point_y),
    .out_arc_length(out_arc_length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Testbench copy of the control points: x/y pairs for start, guide1, guide2, end.
  longint ctl_x [4];
  longint ctl_y [4];

  query_t  pending_queries [$];
  answer_t expected_answers [$];
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int mismatches = 0;
  logic in_taken = 1'b0;

  // ---------------------------------------------------------------------------
  // Curve math. Every lerp is a + floor((b-a)*t / 2^16); the arithmetic shift
  // of a signed 64-bit value gives the floor directly.
  // ---------------------------------------------------------------------------
  function automatic longint lerp16(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> 16);
  endfunction

  function automatic longint bezier_axis(longint p0, longint p1, longint p2,
                                         longint p3, longint t);
    longint a, b, c, d, e;
    a = lerp16(p0, p1, t);
    b = lerp16(p1, p2, t);
    c = lerp16(p2, p3, t);
    d = lerp16(a, b, t);
    e = lerp16(b, c, t);
    return lerp16(d, e, t);
  endfunction

  // Floor of the exact Euclidean chord length; the squared sum fits in 65 bits.
  function automatic longint chord_length(longint dx, longint dy);
    logic [65:0] ax, ay, sq;
    logic [67:0] root, trial;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sq = ax * ax + ay * ay;
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      trial = root | (68'd1 << b);
      if (trial * trial <= {2'b00, sq}) root = trial;
    end
    return longint'(root);
  endfunction

  function automatic answer_t predict_answer(query_t q);
    answer_t r;
    longint pos, n, t, px, py, cx, cy, acc, seg, rem, frac, rx, ry;
    bit found;
    pos = longint'(signed'(q.position));
    n = q.subdivisions;
    if (n == 0) n = 1;
    if (n > MAX_N) n = MAX_N;
    rx = 0; ry = 0; acc = 0; found = 0;
    case (q.op)
      OP_EVAL: begin
        t = (pos < 0) ? 0 : ((pos > 65536) ? 65536 : pos);
        rx = bezier_axis(ctl_x[0], ctl_x[1], ctl_x[2], ctl_x[3], t);
        ry = bezier_axis(ctl_y[0], ctl_y[1], ctl_y[2], ctl_y[3], t);
      end
      OP_LEN, OP_DIST: begin
        px = ctl_x[0];
        py = ctl_y[0];
        if (q.op == OP_DIST && pos <= 0) begin
          rx = px; ry = py; found = 1;
        end
        for (longint i = 1; i <= n && !found; i++) begin
          t = (i * 65536 + n / 2) / n;
          cx = bezier_axis(ctl_x[0], ctl_x[1], ctl_x[2], ctl_x[3], t);
          cy = bezier_axis(ctl_y[0], ctl_y[1], ctl_y[2], ctl_y[3], t);
          seg = chord_length(cx - px, cy - py);
          // Zero-length chords never interpolate; they only add nothing.
          if (q.op == OP_DIST && seg != 0 && acc + seg >= pos) begin
            rem = pos - acc;
            frac = (rem << 16) / seg;
            rx = lerp16(px, cx, frac);
            ry = lerp16(py, cy, frac);
            found = 1;
          end
          acc += seg;
          px = cx;
          py = cy;
        end
        if (q.op == OP_DIST && !found) begin
          rx = ctl_x[3]; ry = ctl_y[3];
        end
      end
      default: ;
    endcase
    r.x = rx[31:0];
    r.y = ry[31:0];
    r.len = (q.op == OP_LEN) ? ((acc > longint'(LEN_MAX)) ? LEN_MAX : acc[LEN_W-1:0]) : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: advance to the next transaction at the falling edge once the
  // current one is taken; hold the payload while stalled.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    query_t q;
    if (!in_valid || in_taken) begin
      if (rst_n && pending_queries.size() > 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        q = pending_queries.pop_front();
        in_op <= q.op;
        in_position <= q.position;
        in_subdivisions <= q.subdivisions;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Monitor: predict on each accepted query, check each accepted result.
  always @(posedge clk) begin
    query_t q;
    answer_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      q.op = in_op;
      q.position = in_position;
      q.subdivisions = in_subdivisions;
      expected_answers.push_back(predict_answer(q));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result x=%h y=%h len=%h",
                   out_point_x, out_point_y, out_arc_length);
      end else begin
        want = expected_answers.pop_front();
        if (out_point_x !== want.x || out_point_y !== want.y ||
            out_arc_length !== want.len) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result mismatch: expected x=%h y=%h len=%h, got x=%h y=%h len=%h",
                     want.x, want.y, want.len, out_point_x, out_point_y, out_arc_length);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Load all eight control point registers and mirror them locally.
  task automatic load_curve(logic [31:0] sx, logic [31:0] sy, logic [31:0] g1x,
                            logic [31:0] g1y, logic [31:0] g2x, logic [31:0] g2y,
                            logic [31:0] ex, logic [31:0] ey);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_GUIDE1_X, g1x);
    write_reg(REG_GUIDE1_Y, g1y);
    write_reg(REG_GUIDE2_X, g2x);
    write_reg(REG_GUIDE2_Y, g2y);
    write_reg(REG_END_X, ex);
    write_reg(REG_END_Y, ey);
    ctl_x[0] = longint'(signed'(sx));  ctl_y[0] = longint'(signed'(sy));
    ctl_x[1] = longint'(signed'(g1x)); ctl_y[1] = longint'(signed'(g1y));
    ctl_x[2] = longint'(signed'(g2x)); ctl_y[2] = longint'(signed'(g2y));
    ctl_x[3] = longint'(signed'(ex));  ctl_y[3] = longint'(signed'(ey));
  endtask

  task automatic queue_query(logic [OP_W-1:0] op, logic [31:0] pos, logic [8:0] n);
    query_t q;
    q.op = op;
    q.position = pos;
    q.subdivisions = n;
    pending_queries.push_back(q);
  endtask

  // Wait until every query is taken and answered, then let the block settle.
  // Check at the rising edge, where the driver's falling-edge updates are stable.
  task automatic drain;
    do @(posedge clk);
    while (pending_queries.size() != 0 || in_valid || expected_answers.size() != 0);
    repeat (40) @(negedge clk);
  endtask

  // Random query: mostly short chord counts, some long ones; distances land
  // mostly within the curve so the walk stops in random chords.
  task automatic queue_random_query;
    query_t q;
    answer_t len_ans;
    logic [8:0] n;
    longint span;
    int pick;
    pick = $urandom_range(99);
    n = ($urandom_range(99) < 4) ? 9'($urandom) : 9'($urandom_range(1, 12));
    if (pick < 30) begin
      queue_query(OP_EVAL, ($urandom_range(9) == 0) ? $urandom : $urandom_range(65536), n);
    end else if (pick < 50) begin
      queue_query(OP_LEN, $urandom, n);
    end else if (pick < 95) begin
      q.op = OP_LEN; q.position = '0; q.subdivisions = n;
      len_ans = predict_answer(q);
      span = longint'(len_ans.len) + longint'(len_ans.len) / 8 + 2;
      if ($urandom_range(9) == 0)
        queue_query(OP_DIST, $urandom, n);
      else
        queue_query(OP_DIST, 32'((longint'($urandom) * 65536 + $urandom) % span), n);
    end else begin
      queue_query(OP_SPARE, $urandom, n);
    end
  endtask

  task automatic run_random(int count, int send_idle, int recv_stall);
    sender_idle_pct = send_idle;
    receiver_stall_pct = recv_stall;
    repeat (count) queue_random_query();
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < 4; i++) begin
      ctl_x[i] = 0;
      ctl_y[i] = 0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Degenerate all-zero curve out of reset.
    queue_query(OP_LEN, 32'd0, 9'd4);
    queue_query(OP_DIST, 32'd100, 9'd4);
    queue_query(OP_EVAL, 32'h8000, 9'd0);
    drain();

    // Directed: a moderate S-curve, every op and special case.
    load_curve(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0003_0000,
               32'h0004_0000, 32'hFFFE_0000, 32'h0005_0000, 32'h0001_0000);
    queue_query(OP_EVAL, 32'hFFFF_FFFF, 9'd1);   // negative t clamps to 0
    queue_query(OP_EVAL, 32'h8000_0000, 9'd1);
    queue_query(OP_EVAL, 32'h0000_0000, 9'd1);
    queue_query(OP_EVAL, 32'h0000_8000, 9'd1);
    queue_query(OP_EVAL, 32'h0001_0000, 9'd1);
    queue_query(OP_EVAL, 32'h7FFF_FFFF, 9'd1);   // t above one clamps to 1
    queue_query(OP_LEN, 32'h0, 9'd0);            // zero chords act as one
    queue_query(OP_LEN, 32'h0, 9'd1);
    queue_query(OP_LEN, 32'h0, 9'd3);
    queue_query(OP_LEN, 32'h0, 9'd256);
    queue_query(OP_LEN, 32'h0, 9'd511);          // clamps to the maximum
    queue_query(OP_DIST, 32'h0000_0000, 9'd8);   // not positive: start point
    queue_query(OP_DIST, 32'h8000_0000, 9'd8);
    queue_query(OP_DIST, 32'h0000_0001, 9'd8);
    queue_query(OP_DIST, 32'h0003_0000, 9'd8);
    queue_query(OP_DIST, 32'h7FFF_FFFF, 9'd8);   // past the end: end point
    queue_query(OP_DIST, 32'h0004_0000, 9'd300);
    queue_query(OP_SPARE, 32'h1234_5678, 9'd5);
    drain();

    // Extreme coordinates: widest chords and lerp spans.
    load_curve(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_query(OP_LEN, 32'h0, 9'd1);
    queue_query(OP_LEN, 32'h0, 9'd256);
    queue_query(OP_EVAL, 32'h0000_4000, 9'd1);
    queue_query(OP_DIST, 32'h7FFF_FFFF, 9'd7);
    run_random(15, 0, 0);

    // Random phases across idling patterns and curves.
    load_curve($urandom_range(32'h000F_FFFF), $urandom_range(32'h000F_FFFF),
               $urandom, $urandom_range(32'h00FF_FFFF),
               $urandom_range(32'h00FF_FFFF), $urandom,
               $urandom_range(32'h000F_FFFF), $urandom_range(32'h000F_FFFF));
    run_random(35, 70, 0);
    load_curve($urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom);
    run_random(35, 0, 70);
    load_curve(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
               32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    run_random(10, 28, 28);                     // point curve: all chords zero
    load_curve($urandom_range(32'h03FF_FFFF), $urandom_range(32'h03FF_FFFF),
               $urandom_range(32'h03FF_FFFF), $urandom_range(32'h03FF_FFFF),
               $urandom_range(32'h03FF_FFFF), $urandom_range(32'h03FF_FFFF),
               $urandom_range(32'h03FF_FFFF), $urandom_range(32'h03FF_FFFF));
    run_random(40, 28, 28);

    drain();
    mismatches += expected_answers.size();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(64'd200_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/cbal_pkg.sv
design/cubic_bezier_arc_length_evaluator.sv
sim/cubic_bezier_arc_length_evaluator_test.sv
